// File: rtl/min_tracking_fifo_top_macros.svh
// Assertion macros for the min-tracking queue.
`ifndef MIN_TRACKING_FIFO_TOP_MACROS_SVH
`define MIN_TRACKING_FIFO_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MTF_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("assertion failed");

`define MTF_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("assertion failed");

`else

`define MTF_ASSERT_IMPL(lbl, ant, cons)

`define MTF_ASSERT_NEXT(lbl, ant, cons)

`endif

`endif

// File: rtl/mtf_pkg.sv
package mtf_pkg;

  localparam int DATA_W              = 64;
  localparam int DEFAULT_QUEUE_DEPTH = 1024;
  localparam int DEFAULT_VALUE_WIDTH = 64;

  typedef enum logic [1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_CLR = 2'd2,
    MODE_NOP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

endpackage

// File: rtl/mtf_ram.sv
module mtf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/min_tracking_fifo_top.sv
// Channel   Direction  Ports                                      Handshake
// in        input      in_mode, in_value                          in_valid / in_ready
// out       output     out_status, out_removed_value, out_front_value,
//                      out_min_value, out_count, out_empty_res    out_valid / out_ready
//
// One command at a time; in_ready is high only while the sequencer is idle. An enqueue
// drops tail candidates one compare at a time against the registered candidate read,
// then appends the new value as a candidate.
// A waiting result holds the sequencer in its last state; a new command is still taken
// while the result register is full. Synchronous active-low reset clears pointers and counts.
`include "min_tracking_fifo_top_macros.svh"

module min_tracking_fifo_top
  import mtf_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_mode,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_min_value,
  output logic [CNT_W-1:0]         out_count,
  output logic                     out_empty_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CRD,
    S_CCMP,
    S_CAPP,
    S_DQCMP,
    S_RD,
    S_RSP
  } state_t;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  state_t                  state_r;
  mode_t                   mode_r;
  logic [VALUE_WIDTH-1:0]  val_r;
  status_t                 stat_r;
  logic signed [DATA_W-1:0] rem_r;

  logic [PTR_W-1:0] rd_ptr_r, wr_ptr_r, c_head_r, c_tail_r;
  logic [CNT_W-1:0] held_cnt_r, c_cnt_r;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_rem_r, out_front_r, out_min_r;
  logic [CNT_W-1:0]         out_count_r;
  logic                     out_empty_r;

  logic                   ent_we, ent_re, cand_we, cand_re;
  logic [PTR_W-1:0]       cand_raddr, tail_prev;
  logic [VALUE_WIDTH-1:0] ent_rdata, cand_rdata;
  logic signed [VALUE_WIDTH-1:0] ent_s, cand_s, val_s;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  assign ent_s     = ent_rdata;
  assign cand_s    = cand_rdata;
  assign val_s     = val_r;
  assign tail_prev = ptr_dec(c_tail_r);

  always_comb begin
    ent_we     = (state_r == S_EXEC) && (mode_r == MODE_ENQ) && (held_cnt_r < CNT_FULL);
    ent_re     = (state_r == S_EXEC) || (state_r == S_RD);
    cand_we    = (state_r == S_CAPP);
    cand_re    = (state_r == S_EXEC) || (state_r == S_RD) || (state_r == S_CRD);
    cand_raddr = (state_r == S_CRD) ? tail_prev : c_head_r;
  end

  mtf_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (wr_ptr_r),
    .wdata (val_r),
    .re    (ent_re),
    .raddr (rd_ptr_r),
    .rdata (ent_rdata)
  );

  mtf_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(QUEUE_DEPTH)) u_cand_ram (
    .clk   (clk),
    .we    (cand_we),
    .waddr (c_tail_r),
    .wdata (val_r),
    .re    (cand_re),
    .raddr (cand_raddr),
    .rdata (cand_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      c_head_r    <= '0;
      c_tail_r    <= '0;
      held_cnt_r  <= '0;
      c_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_RSP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= mode_t'(in_mode);
            val_r   <= in_value[VALUE_WIDTH-1:0];
            stat_r  <= STAT_OK;
            rem_r   <= '0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (mode_r)
            MODE_ENQ: begin
              if (held_cnt_r >= CNT_FULL) begin
                stat_r  <= STAT_FULL;
                state_r <= S_RD;
              end else begin
                wr_ptr_r   <= ptr_inc(wr_ptr_r);
                held_cnt_r <= held_cnt_r + 1'b1;
                state_r    <= S_CRD;
              end
            end
            MODE_DEQ: begin
              if (held_cnt_r == '0) begin
                stat_r  <= STAT_EMPTY;
                state_r <= S_RD;
              end else begin
                state_r <= S_DQCMP;
              end
            end
            MODE_CLR: begin
              rd_ptr_r   <= '0;
              wr_ptr_r   <= '0;
              c_head_r   <= '0;
              c_tail_r   <= '0;
              held_cnt_r <= '0;
              c_cnt_r    <= '0;
              state_r    <= S_RD;
            end
            MODE_NOP: begin
              state_r <= S_RD;
            end
          endcase
        end
        S_CRD: begin
          // read the tail candidate, or append once none remain
          state_r <= (c_cnt_r == '0) ? S_CAPP : S_CCMP;
        end
        S_CCMP: begin
          if (cand_s > val_s) begin
            c_tail_r <= tail_prev;
            c_cnt_r  <= c_cnt_r - 1'b1;
            state_r  <= S_CRD;
          end else begin
            state_r <= S_CAPP;
          end
        end
        S_CAPP: begin
          c_tail_r <= ptr_inc(c_tail_r);
          c_cnt_r  <= c_cnt_r + 1'b1;
          state_r  <= S_RD;
        end
        S_DQCMP: begin
          rd_ptr_r   <= ptr_inc(rd_ptr_r);
          held_cnt_r <= held_cnt_r - 1'b1;
          rem_r      <= DATA_W'(ent_s);
          // drop the head candidate when it is the value leaving
          if ((c_cnt_r != '0) && (cand_rdata == ent_rdata)) begin
            c_head_r <= ptr_inc(c_head_r);
            c_cnt_r  <= c_cnt_r - 1'b1;
          end
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_RSP;
        end
        S_RSP: begin
          // hold until the result register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= stat_r;
            out_rem_r    <= rem_r;
            out_front_r  <= (held_cnt_r == '0) ? '0 : DATA_W'(ent_s);
            out_min_r    <= ((held_cnt_r == '0) || (c_cnt_r == '0)) ? '0 : DATA_W'(cand_s);
            out_count_r  <= held_cnt_r;
            out_empty_r  <= (held_cnt_r == '0);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_rem_r;
  assign out_front_value   = out_front_r;
  assign out_min_value     = out_min_r;
  assign out_count         = out_count_r;
  assign out_empty_res     = out_empty_r;

  `MTF_ASSERT_IMPL(a_cnt_bound, 1'b1, held_cnt_r <= CNT_FULL)
  `MTF_ASSERT_IMPL(a_cand_le_held, 1'b1, c_cnt_r <= held_cnt_r)
  `MTF_ASSERT_IMPL(a_cand_nonempty, (state_r == S_IDLE) && (held_cnt_r != '0), c_cnt_r != '0)
  `MTF_ASSERT_NEXT(a_rsp_to_valid, (state_r == S_RSP) && (!out_valid_r || out_ready), out_valid_r)

endmodule

// File: test/tb_min_tracking_fifo_top.sv
`timescale 1ns / 100ps

module tb_min_tracking_fifo_top;
  import mtf_pkg::*;

  localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
  localparam int CNT_W       = $clog2(DEFAULT_QUEUE_DEPTH + 1);
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] removed;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] minimum;
    logic [CNT_W-1:0]         count;
    logic                     empty;
  } queue_report_t;

  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] value;
    logic              settle_first;
  } command_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_mode = MODE_NOP;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_removed_value;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_min_value;
  logic [CNT_W-1:0]         out_count;
  logic                     out_empty_res;

  // Shadow of the queue contents and of the non-decreasing minimum candidates
  logic signed [DATA_W-1:0] held_vals[$];
  logic signed [DATA_W-1:0] min_cands[$];
  queue_report_t            pending_reports[$];
  command_t                 cmd_backlog[$];

  int items_accepted = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int cycles         = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int send_gap       = 0;
  int send_calm      = 0;
  int recv_stall     = 0;
  int recv_calm      = 0;

  min_tracking_fifo_top u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic step_min_queue(input logic [1:0] mode,
                                input logic signed [DATA_W-1:0] value);
    queue_report_t rep;
    logic signed [DATA_W-1:0] taken;
    rep = '0;
    rep.status = STAT_OK;
    case (mode)
      MODE_ENQ: begin
        if (held_vals.size() >= DEPTH) begin
          rep.status = STAT_FULL;
        end else begin
          held_vals.push_back(value);
          // drop tail candidates strictly above the new value; equal ones stay
          while (min_cands.size() != 0 && min_cands[$] > value)
            void'(min_cands.pop_back());
          min_cands.push_back(value);
        end
      end
      MODE_DEQ: begin
        if (held_vals.size() == 0) begin
          rep.status = STAT_EMPTY;
        end else begin
          taken = held_vals.pop_front();
          if (min_cands.size() != 0 && min_cands[0] == taken)
            void'(min_cands.pop_front());
          rep.removed = taken;
        end
      end
      MODE_CLR: begin
        held_vals.delete();
        min_cands.delete();
      end
      default: ;
    endcase
    rep.count = CNT_W'(held_vals.size());
    rep.empty = (held_vals.size() == 0);
    if (held_vals.size() != 0) begin
      rep.front = held_vals[0];
      if (min_cands.size() != 0)
        rep.minimum = min_cands[0];
    end
    pending_reports.push_back(rep);
  endtask

  function automatic int pick_idle();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint rand_value();
    int r;
    r = $urandom_range(99);
    if (r < 4)
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (r < 8)
      return longint'(64'h8000_0000_0000_0000);
    if (r < 15)
      return longint'($urandom_range(2)) - 1;
    if (r < 55)
      return longint'($urandom_range(16)) - 8;
    return longint'({$urandom, $urandom});
  endfunction

  task automatic add_cmd(input mode_t mode, input longint value, input logic settle);
    command_t c;
    c.mode = mode;
    c.value = value;
    c.settle_first = settle;
    cmd_backlog.push_back(c);
  endtask

  always @(posedge clk) begin : driver
    command_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        step_min_queue(in_mode, in_value);
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0 && hold_left == 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0 &&
                     (!cmd_backlog[0].settle_first ||
                      (!in_valid && results_seen == items_accepted))) begin
          cmd = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          in_mode <= cmd.mode;
          in_value <= cmd.value;
          if (send_calm != 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = pick_idle();
            if ($urandom_range(63) == 0)
              send_calm = $urandom_range(20, 80);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    queue_report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (pending_reports.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result beat with no command outstanding", $time);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (out_status !== want.status || out_removed_value !== want.removed ||
              out_front_value !== want.front || out_min_value !== want.minimum ||
              out_count !== want.count || out_empty_res !== want.empty) begin
            if (mismatches < MAX_REPORTS) begin
              $display("%0t: expected status %0d removed %0d front %0d min %0d count %0d empty %0d",
                       $time, want.status, want.removed, want.front, want.minimum,
                       want.count, want.empty);
              $display("%0t: actual   status %0d removed %0d front %0d min %0d count %0d empty %0d",
                       $time, out_status, out_removed_value, out_front_value,
                       out_min_value, out_count, out_empty_res);
            end
            mismatches++;
          end
        end
        if (recv_calm != 0) begin
          recv_calm--;
          recv_stall = 0;
        end else begin
          recv_stall = pick_idle();
          if ($urandom_range(63) == 0)
            recv_calm = $urandom_range(20, 80);
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int     total;
    int     n;
    int     len;
    int     r;
    int     stride;
    longint base;
    logic   settle;
    mode_t  mode;

    // Directed: empty errors, extremes, duplicate minima, clear, unused mode
    add_cmd(MODE_DEQ, 0, 1'b0);
    add_cmd(MODE_NOP, longint'(64'hA5A5_5A5A_F0F0_0F0F), 1'b0);
    add_cmd(MODE_ENQ, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);
    add_cmd(MODE_ENQ, longint'(64'h8000_0000_0000_0000), 1'b0);
    add_cmd(MODE_ENQ, 0, 1'b0);
    add_cmd(MODE_ENQ, -1, 1'b0);
    add_cmd(MODE_ENQ, longint'(64'h8000_0000_0000_0000), 1'b0);
    add_cmd(MODE_ENQ, 1, 1'b0);
    add_cmd(MODE_NOP, -1, 1'b0);
    repeat (5) add_cmd(MODE_DEQ, 0, 1'b0);
    add_cmd(MODE_CLR, longint'(64'h5A5A_A5A5_0F0F_F0F0), 1'b0);
    add_cmd(MODE_DEQ, 0, 1'b0);
    add_cmd(MODE_ENQ, 5, 1'b0);
    add_cmd(MODE_ENQ, 3, 1'b0);
    add_cmd(MODE_ENQ, 3, 1'b0);
    add_cmd(MODE_ENQ, 7, 1'b0);
    repeat (3) add_cmd(MODE_DEQ, 0, 1'b0);
    add_cmd(MODE_CLR, 0, 1'b0);
    add_cmd(MODE_NOP, 0, 1'b0);

    // Fill to the brim, push against full, churn near full, then clear
    add_cmd(MODE_CLR, 0, 1'b1);
    repeat (DEPTH + 6) add_cmd(MODE_ENQ, rand_value(), 1'b0);
    repeat (80) add_cmd($urandom_range(1) ? MODE_ENQ : MODE_DEQ, rand_value(), 1'b0);
    add_cmd(MODE_CLR, 0, 1'b1);

    // Random segments
    n = 0;
    while (n < 80) begin
      settle = ($urandom_range(7) == 0);
      r = $urandom_range(9);
      if (r < 2) begin
        len = $urandom_range(1, 40);
        repeat (len) begin
          add_cmd(MODE_ENQ, rand_value(), settle);
          settle = 1'b0;
        end
      end else if (r < 3) begin
        len = $urandom_range(1, 40);
        repeat (len) begin
          add_cmd(MODE_DEQ, rand_value(), settle);
          settle = 1'b0;
        end
      end else if (r < 7) begin
        len = $urandom_range(10, 40);
        repeat (len) begin
          r = $urandom_range(99);
          if (r < 55)
            mode = MODE_ENQ;
          else if (r < 88)
            mode = MODE_DEQ;
          else if (r < 97)
            mode = MODE_NOP;
          else
            mode = MODE_CLR;
          add_cmd(mode, rand_value(), settle);
          settle = 1'b0;
        end
      end else if (r < 9) begin
        // rising run, then one value below it all to drop a long candidate tail
        len = $urandom_range(5, 60);
        base = longint'($urandom_range(2000)) - 1000;
        stride = $urandom_range(0, 50);
        for (int i = 0; i < len; i++) begin
          add_cmd(MODE_ENQ, base + longint'(i) * stride, settle);
          settle = 1'b0;
        end
        add_cmd(MODE_ENQ, base - 1 - longint'($urandom_range(100)), 1'b0);
        len++;
      end else begin
        len = 1;
        add_cmd(MODE_CLR, rand_value(), settle);
      end
      n += len;
    end

    total = cmd_backlog.size();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted != total || results_seen != total)
      @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatches == 0 && pending_reports.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
